@@ design/rcpm_pkg.sv @@
// Shared types and constants for the resource counter peak monitor.
package rcpm_pkg;

  localparam int CMD_WIDTH   = 2;
  localparam int INDEX_WIDTH = 4;
  localparam int DELTA_WIDTH = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int WIDE_WIDTH  = 64;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_UPDATE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_POLL   = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic                   set;
    logic                   poll;
    logic [INDEX_WIDTH-1:0] index;
  } mark_ctl_t;

endpackage

@@ design/rcpm_if.sv @@
// Handshake channels for command words and result words.
interface rcpm_item_if;
  logic                                valid;
  logic                                ready;
  logic [rcpm_pkg::CMD_WIDTH-1:0]      cmd;
  logic [rcpm_pkg::INDEX_WIDTH-1:0]    counter_index;
  logic signed [rcpm_pkg::DELTA_WIDTH-1:0] delta;
  logic                                want_peak;

  modport source (output valid, cmd, counter_index, delta, want_peak, input ready);
  modport sink (input valid, cmd, counter_index, delta, want_peak, output ready);
endinterface

interface rcpm_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [rcpm_pkg::VALUE_WIDTH-1:0] value;
  logic [rcpm_pkg::INDEX_WIDTH-1:0]    changed_index;

  modport source (output valid, value, changed_index, input ready);
  modport sink (input valid, value, changed_index, output ready);
endinterface

@@ design/rcpm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rcpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/rcpm_marks.sv @@
// Changed marks, summary flag and lowest-index priority encoder.
module rcpm_marks #(
  parameter int NUM_MARKS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rcpm_pkg::mark_ctl_t             ctl,
  output logic [rcpm_pkg::INDEX_WIDTH-1:0] found
);
  import rcpm_pkg::*;

  localparam int AW = $clog2(NUM_MARKS);

  logic [NUM_MARKS-1:0] marks;
  logic                 any_update;
  logic [INDEX_WIDTH-1:0] lowest;

  always_comb begin
    lowest = '0;
    for (int i = NUM_MARKS - 1; i >= 1; i--) begin
      if (marks[i]) begin
        lowest = INDEX_WIDTH'(i);
      end
    end
  end

  assign found = any_update ? lowest : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      marks      <= '0;
      any_update <= 1'b0;
    end else if (ctl.set) begin
      marks[ctl.index[AW-1:0]] <= 1'b1;
      any_update               <= 1'b1;
    end else if (ctl.poll && any_update) begin
      any_update <= 1'b0;
      if (lowest != '0) begin
        marks[lowest[AW-1:0]] <= 1'b0;
      end
    end
  end

endmodule

@@ design/resource_counter_peak_monitor.sv @@
// Top level of the resource counter peak monitor.
//
// Command words arrive on the item channel: update adds a signed delta to a
// counter and tracks its peak, read returns the current or peak count, and
// poll reports the lowest changed counter once per batch of updates.
// Every command word yields exactly one result word on the result channel.
// The counts and peaks live in two RAMs with a registered read.
// A word is read from the RAMs on the edge that accepts it; the execute
// state then modifies, writes back and loads the result register once
// the result register is free. The block takes no new word until the
// result of the last one is loaded. Only one word is in flight, so a
// write-back always lands before the next read and no forwarding is
// needed.
// Reset clears the changed marks, the summary flag, the result valid flag and
// the per-entry valid bits, so every counter and peak reads as zero at once.
// When the receiver stalls, the finished word waits in the result register
// and the next word waits in the execute stage; the input then holds off.
module resource_counter_peak_monitor #(
  parameter int NUM_COUNTERS = 16,
  parameter int COUNT_WIDTH  = 32
) (
  input logic          clk,
  input logic          rst,
  rcpm_item_if.sink    item,
  rcpm_result_if.source result
);
  import rcpm_pkg::*;

  localparam int NUM_MARKS = (NUM_COUNTERS < (1 << INDEX_WIDTH)) ?
                             NUM_COUNTERS : (1 << INDEX_WIDTH);
  localparam int AW = $clog2(NUM_MARKS);

  state_t state, state_next;

  logic [CMD_WIDTH-1:0]          op_cmd;
  logic [INDEX_WIDTH-1:0]        op_index;
  logic                          op_ok;
  logic signed [DELTA_WIDTH-1:0] op_delta;
  logic                          op_peak;
  logic                          op_init;

  logic [NUM_MARKS-1:0] entry_valid;
  logic                 accept;
  logic                 done;
  logic                 in_range;
  logic                 write_en;
  logic [AW-1:0]        rd_addr;

  logic [COUNT_WIDTH-1:0] cur_rd, peak_rd;
  logic signed [COUNT_WIDTH-1:0] cur, peak, sum, new_peak, sel;
  logic signed [WIDE_WIDTH-1:0] wide;

  logic                          res_valid;
  logic signed [VALUE_WIDTH-1:0] res_value, res_value_next;
  logic [INDEX_WIDTH-1:0]        res_index, res_index_next;
  logic [INDEX_WIDTH-1:0]        found;
  mark_ctl_t                     mark_ctl;

  assign accept   = item.valid && item.ready;
  assign in_range = (item.counter_index != '0) &&
                    ({1'b0, item.counter_index} < (INDEX_WIDTH + 1)'(NUM_MARKS));

  // While a word waits in the execute stage the RAMs keep reading its entry.
  assign rd_addr = accept ? item.counter_index[AW-1:0] : op_index[AW-1:0];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item.valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!res_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item.ready = 1'b0;
    done       = 1'b0;
    case (state)
      ST_IDLE: item.ready = 1'b1;
      ST_EXEC: done = !res_valid || result.ready;
      default: begin
        item.ready = 1'b0;
        done       = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd   <= item.cmd;
      op_index <= item.counter_index;
      op_ok    <= in_range;
      op_delta <= item.delta;
      op_peak  <= item.want_peak;
      op_init  <= entry_valid[item.counter_index[AW-1:0]];
    end
  end

  rcpm_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_MARKS)) u_cur_ram (
    .clk   (clk),
    .we    (write_en),
    .waddr (op_index[AW-1:0]),
    .wdata (sum),
    .raddr (rd_addr),
    .rdata (cur_rd)
  );

  rcpm_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_MARKS)) u_peak_ram (
    .clk   (clk),
    .we    (write_en),
    .waddr (op_index[AW-1:0]),
    .wdata (new_peak),
    .raddr (rd_addr),
    .rdata (peak_rd)
  );

  assign cur      = op_init ? cur_rd : '0;
  assign peak     = op_init ? peak_rd : '0;
  assign sum      = cur + COUNT_WIDTH'(op_delta);
  assign new_peak = (sum > peak) ? sum : peak;
  assign sel      = op_peak ? peak : cur;
  assign wide     = WIDE_WIDTH'(sel);
  assign write_en = done && (op_cmd == CMD_UPDATE) && op_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (write_en) begin
      entry_valid[op_index[AW-1:0]] <= 1'b1;
    end
  end

  assign mark_ctl.set   = write_en;
  assign mark_ctl.poll  = done && (op_cmd == CMD_POLL);
  assign mark_ctl.index = op_index;

  rcpm_marks #(.NUM_MARKS(NUM_MARKS)) u_marks (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mark_ctl),
    .found (found)
  );

  always_comb begin
    res_value_next = '0;
    res_index_next = '0;
    if (op_cmd == CMD_READ) begin
      res_value_next = op_ok ? wide[VALUE_WIDTH-1:0] : '1;
    end
    if (op_cmd == CMD_POLL) begin
      res_index_next = found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (done) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_value <= res_value_next;
      res_index <= res_index_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.value         = res_value;
  assign result.changed_index = res_index;

endmodule

@@ sim/tb_resource_counter_peak_monitor.sv @@
// Self-checking testbench for the resource counter peak monitor: directed and random words.
module tb_resource_counter_peak_monitor;
  import rcpm_pkg::*;

  localparam int N_COUNTERS = 16;
  localparam int WORD_TARGET = 1650;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [CMD_WIDTH-1:0] CMD_UNDEF = 2'd3;

  class counter_bank_scoreboard;
    logic signed [VALUE_WIDTH-1:0] count_now [N_COUNTERS];
    logic signed [VALUE_WIDTH-1:0] count_peak [N_COUNTERS];
    bit marks [N_COUNTERS];
    bit summary;
    logic signed [VALUE_WIDTH-1:0] exp_value [$];
    logic [INDEX_WIDTH-1:0] exp_index [$];
    int errors;

    function new();
      for (int i = 0; i < N_COUNTERS; i++) begin
        count_now[i] = '0;
        count_peak[i] = '0;
        marks[i] = 1'b0;
      end
      summary = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return exp_value.size();
    endfunction

    function void note_word(logic [CMD_WIDTH-1:0] cmd, logic [INDEX_WIDTH-1:0] idx,
                            logic signed [DELTA_WIDTH-1:0] delta, logic want_peak);
      logic signed [VALUE_WIDTH-1:0] value;
      logic signed [VALUE_WIDTH-1:0] sum;
      logic [INDEX_WIDTH-1:0] found;
      value = '0;
      found = '0;
      case (cmd)
        CMD_UPDATE: begin
          if (idx != 0 && int'(idx) < N_COUNTERS) begin
            sum = count_now[idx] + delta;
            count_now[idx] = sum;
            if (sum > count_peak[idx]) count_peak[idx] = sum;
            marks[idx] = 1'b1;
            summary = 1'b1;
          end
        end
        CMD_READ: begin
          if (idx == 0 || int'(idx) >= N_COUNTERS) value = -1;
          else value = want_peak ? count_peak[idx] : count_now[idx];
        end
        CMD_POLL: begin
          if (summary) begin
            summary = 1'b0;
            for (int i = 1; i < N_COUNTERS; i++) begin
              if (marks[i] && found == 0) begin
                marks[i] = 1'b0;
                found = INDEX_WIDTH'(i);
              end
            end
          end
        end
        default: begin
        end
      endcase
      exp_value.push_back(value);
      exp_index.push_back(found);
    endfunction

    function void check_result(logic signed [VALUE_WIDTH-1:0] value,
                               logic [INDEX_WIDTH-1:0] changed_index);
      logic signed [VALUE_WIDTH-1:0] want_value;
      logic [INDEX_WIDTH-1:0] want_index;
      if (exp_value.size() == 0) begin
        $error("unexpected result word: value %0d, changed_index %0d", value, changed_index);
        errors++;
        return;
      end
      want_value = exp_value.pop_front();
      want_index = exp_index.pop_front();
      if (value !== want_value) begin
        $error("value mismatch: expected %0d, actual %0d", want_value, value);
        errors++;
      end
      if (changed_index !== want_index) begin
        $error("changed_index mismatch: expected %0d, actual %0d", want_index, changed_index);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  rcpm_item_if item_ch ();
  rcpm_result_if result_ch ();

  resource_counter_peak_monitor #(
    .NUM_COUNTERS(N_COUNTERS),
    .COUNT_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch)
  );

  counter_bank_scoreboard sb;
  int words_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  initial begin
    item_ch.valid <= 1'b0;
    item_ch.cmd <= CMD_UPDATE;
    item_ch.counter_index <= '0;
    item_ch.delta <= '0;
    item_ch.want_peak <= 1'b0;
    result_ch.ready <= 1'b0;
  end

  task automatic send_word(logic [CMD_WIDTH-1:0] cmd, logic [INDEX_WIDTH-1:0] idx,
                           logic signed [DELTA_WIDTH-1:0] delta, logic want_peak);
    item_ch.valid <= 1'b1;
    item_ch.cmd <= cmd;
    item_ch.counter_index <= idx;
    item_ch.delta <= delta;
    item_ch.want_peak <= want_peak;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_word(cmd, idx, delta, want_peak);
    words_sent++;
  endtask

  task automatic issue(logic [CMD_WIDTH-1:0] cmd, logic [INDEX_WIDTH-1:0] idx,
                       logic signed [DELTA_WIDTH-1:0] delta, logic want_peak);
    int gap;
    send_word(cmd, idx, delta, want_peak);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic signed [DELTA_WIDTH-1:0] rand_delta();
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 200)) - 100;
      1: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 1;
          3: return -1;
          default: return 0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_WIDTH-1:0] rand_cmd();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 8) return CMD_UPDATE;
    if (pick < 14) return CMD_READ;
    if (pick < 19) return CMD_POLL;
    return CMD_UNDEF;
  endfunction

  task automatic run_directed();
    issue(CMD_READ, 4'd0, 0, 1'b0);
    issue(CMD_READ, 4'd0, 0, 1'b1);
    issue(CMD_POLL, 4'd0, 0, 1'b0);
    issue(CMD_UPDATE, 4'd0, 32'sd77, 1'b0);
    issue(CMD_POLL, 4'd5, 0, 1'b0);
    issue(CMD_UPDATE, 4'd15, 32'sh7FFF_FFFF, 1'b0);
    issue(CMD_READ, 4'd15, 0, 1'b1);
    issue(CMD_UPDATE, 4'd15, 32'sd1, 1'b0);
    issue(CMD_READ, 4'd15, 0, 1'b0);
    issue(CMD_READ, 4'd15, 0, 1'b1);
    issue(CMD_UPDATE, 4'd1, 32'sh8000_0000, 1'b1);
    issue(CMD_READ, 4'd1, 0, 1'b1);
    issue(CMD_UPDATE, 4'd3, -32'sd1, 1'b0);
    issue(CMD_UPDATE, 4'd7, 32'sd5, 1'b0);
    issue(CMD_POLL, 4'd0, 0, 1'b0);
    issue(CMD_POLL, 4'd0, 0, 1'b0);
    issue(CMD_UPDATE, 4'd7, 32'sd0, 1'b0);
    issue(CMD_POLL, 4'd0, 0, 1'b0);
    issue(CMD_POLL, 4'd0, 0, 1'b0);
    issue(CMD_UNDEF, 4'hF, 32'shFFFF_FFFF, 1'b1);
    issue(CMD_UPDATE, 4'd2, 32'sd0, 1'b0);
    issue(CMD_READ, 4'd2, 0, 1'b0);
    issue(CMD_READ, 4'd2, 0, 1'b1);
    issue(CMD_POLL, 4'hF, 32'sh7FFF_FFFF, 1'b1);
  endtask

  task automatic run_random();
    int n;
    while (words_sent < WORD_TARGET) begin
      if ($urandom_range(0, 9) < 6) begin
        n = $urandom_range(1, 6);
        repeat (n) issue(CMD_UPDATE, INDEX_WIDTH'($urandom_range(1, 15)), rand_delta(),
                         1'($urandom_range(0, 1)));
        n = $urandom_range(1, 4);
        repeat (n) begin
          issue(CMD_POLL, INDEX_WIDTH'($urandom_range(0, 15)), rand_delta(),
                1'($urandom_range(0, 1)));
          if ($urandom_range(0, 1))
            issue(CMD_UPDATE, INDEX_WIDTH'($urandom_range(1, 15)), rand_delta(),
                  1'($urandom_range(0, 1)));
          issue(CMD_READ, INDEX_WIDTH'($urandom_range(1, 15)), rand_delta(),
                1'($urandom_range(0, 1)));
        end
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) issue(rand_cmd(), INDEX_WIDTH'($urandom_range(0, 15)), rand_delta(),
                         1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int mode;
    int mode_left;
    int run_left;
    logic next_ready;
    mode = 0;
    mode_left = 0;
    run_left = 0;
    next_ready = 1'b1;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready)
        sb.check_result(result_ch.value, result_ch.changed_index);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 150);
      end
      mode_left--;
      case (mode)
        0: next_ready = 1'b1;
        1: next_ready = ($urandom_range(0, 3) != 0);
        2: next_ready = 1'($urandom_range(0, 1));
        default: begin
          if (run_left == 0) begin
            next_ready = ~next_ready;
            run_left = $urandom_range(1, 8);
          end
          run_left--;
        end
      endcase
      result_ch.ready <= next_ready;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
